/* sv/nmskg_pkg.sv */
// Shared types and constants of the NMS keep-mask gather block.
package nmskg_pkg;

   localparam int BOX_COUNT_W = 13;
   localparam int INDEX_W     = 12;
   localparam int TOTAL_W     = 13;
   localparam int MASK_W      = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 3;
   localparam int QUEUE_CNT_W = 2;
   localparam int QUEUE_PTR_W = 2;

   // register index, taken from csr_paddr[2]
   localparam logic REG_BOX_COUNT = 1'b0;

   localparam logic [BOX_COUNT_W-1:0] BOX_COUNT_RESET = BOX_COUNT_W'(1);

   typedef struct packed {
      logic own_word;
      logic past_own;
      logic row_end;
      logic set_end;
   } walk_ctl_type;

   typedef struct packed {
      logic               is_kept;
      logic [INDEX_W-1:0] kept_index;
      logic               finished;
      logic [TOTAL_W-1:0] kept_total;
   } rsp_type;

endpackage

/* sv/nmskg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module nmskg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/nmskg_walk.sv */
// Row and word counters: tags each accepted mask word and issues the bitmap read.
module nmskg_walk #(
   parameter int MAX_BOXES = 4096,
   parameter int WORD_BITS = 32,
   parameter int DEPTH     = (MAX_BOXES + WORD_BITS - 1) / WORD_BITS,
   parameter int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int BIT_W     = $clog2(WORD_BITS),
   parameter int N_W       = $clog2(MAX_BOXES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          accept,
   input  logic [N_W-1:0]                box_num,
   input  logic [nmskg_pkg::MASK_W-1:0]  mask_word,
   output logic                          rd_en,
   output logic [ADDR_W-1:0]             rd_addr,
   output logic                          s1_valid,
   output logic [WORD_BITS-1:0]          s1_word,
   output logic [ADDR_W-1:0]             s1_addr,
   output logic [BIT_W-1:0]              s1_bit,
   output logic [nmskg_pkg::INDEX_W-1:0] s1_row,
   output nmskg_pkg::walk_ctl_type       s1_ctl
);
   import nmskg_pkg::*;

   localparam int ROW_W = $clog2(MAX_BOXES);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0] own_ff, own_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              s1_valid_ff;
   logic              col_end;
   logic              row_end;
   walk_ctl_type      ctl;

   logic [WORD_BITS-1:0] s1_word_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [BIT_W-1:0]     s1_bit_ff;
   logic [INDEX_W-1:0]   s1_row_ff;
   walk_ctl_type         s1_ctl_ff;

   always_comb begin
      col_end = ((32'(col_ff) + 32'd1) * 32'(WORD_BITS)) >= 32'(box_num);
      row_end = (32'(row_ff) + 32'd1) >= 32'(box_num);

      ctl.own_word = (col_ff == own_ff);
      ctl.past_own = (col_ff > own_ff);
      ctl.row_end  = col_end;
      ctl.set_end  = col_end && row_end;

      row_in = row_ff;
      col_in = col_ff + ADDR_W'(1);
      own_in = own_ff;
      bit_in = bit_ff;
      if (col_end) begin
         col_in = '0;
         if (row_end) begin
            row_in = '0;
            own_in = '0;
            bit_in = '0;
         end else begin
            row_in = row_ff + ROW_W'(1);
            if (32'(bit_ff) == WORD_BITS - 1) begin
               bit_in = '0;
               own_in = own_ff + ADDR_W'(1);
            end else begin
               bit_in = bit_ff + BIT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_ff      <= '0;
         col_ff      <= '0;
         own_ff      <= '0;
         bit_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
            own_ff <= own_in;
            bit_ff <= bit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= WORD_BITS'(mask_word);
         s1_addr_ff <= col_ff;
         s1_bit_ff  <= bit_ff;
         s1_row_ff  <= INDEX_W'(row_ff);
         s1_ctl_ff  <= ctl;
      end
   end

   assign rd_en    = accept;
   assign rd_addr  = col_ff;
   assign s1_valid = s1_valid_ff;
   assign s1_word  = s1_word_ff;
   assign s1_addr  = s1_addr_ff;
   assign s1_bit   = s1_bit_ff;
   assign s1_row   = s1_row_ff;
   assign s1_ctl   = s1_ctl_ff;

endmodule

/* sv/nmskg_rmw.sv */
// Bitmap read-modify-write, keep decision and kept count.
module nmskg_rmw #(
   parameter int MAX_BOXES = 4096,
   parameter int WORD_BITS = 32,
   parameter int DEPTH     = (MAX_BOXES + WORD_BITS - 1) / WORD_BITS,
   parameter int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int BIT_W     = $clog2(WORD_BITS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          s1_valid,
   input  logic [WORD_BITS-1:0]          s1_word,
   input  logic [ADDR_W-1:0]             s1_addr,
   input  logic [BIT_W-1:0]              s1_bit,
   input  logic [nmskg_pkg::INDEX_W-1:0] s1_row,
   input  nmskg_pkg::walk_ctl_type       s1_ctl,
   input  logic [WORD_BITS-1:0]          rd_data,
   output logic                          wr_en,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [WORD_BITS-1:0]          wr_data,
   output logic                          push,
   output nmskg_pkg::rsp_type            push_data
);
   import nmskg_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   logic [DEPTH-1:0]     valid_ff, valid_in;
   logic                 fwd_ff;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   logic [WORD_BITS-1:0] fwd_data_ff;
   logic                 row_kept_ff;
   logic [CNT_W-1:0]     kept_ff, kept_in;

   logic [WORD_BITS-1:0] cur_word;
   logic                 kept_now;
   logic                 flag_eff;
   logic                 do_write;

   always_comb begin
      if (fwd_ff && (fwd_addr_ff == s1_addr)) begin
         cur_word = fwd_data_ff;
      end else if (valid_ff[s1_addr]) begin
         cur_word = rd_data;
      end else begin
         cur_word = '0;
      end

      kept_now = s1_valid && s1_ctl.own_word && !cur_word[s1_bit];
      flag_eff = row_kept_ff || kept_now;
      do_write = s1_valid && (s1_ctl.own_word || s1_ctl.past_own) && flag_eff;
      kept_in  = kept_ff + CNT_W'(kept_now);

      valid_in = valid_ff;
      if (s1_valid && s1_ctl.set_end) begin
         valid_in = '0;
      end else if (do_write) begin
         valid_in[s1_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         fwd_ff      <= 1'b0;
         row_kept_ff <= 1'b0;
         kept_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         fwd_ff   <= do_write && !s1_ctl.set_end;
         if (s1_valid) begin
            row_kept_ff <= s1_ctl.row_end ? 1'b0 : flag_eff;
            kept_ff     <= s1_ctl.set_end ? '0 : kept_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_addr;
      fwd_data_ff <= cur_word | s1_word;
   end

   assign wr_en   = do_write;
   assign wr_addr = s1_addr;
   assign wr_data = cur_word | s1_word;

   assign push                 = s1_valid && (kept_now || s1_ctl.set_end);
   assign push_data.is_kept    = kept_now;
   assign push_data.kept_index = s1_row;
   assign push_data.finished   = s1_ctl.set_end;
   assign push_data.kept_total = TOTAL_W'(kept_in);

endmodule

/* sv/nmskg_outq.sv */
// Three-entry result queue in front of the result channel.
module nmskg_outq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  nmskg_pkg::rsp_type                push_data,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output nmskg_pkg::rsp_type                rsp_data,
   output logic [nmskg_pkg::QUEUE_CNT_W-1:0] count
);
   import nmskg_pkg::*;

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   pop;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (32'(p) == QUEUE_DEPTH - 1) begin
         return '0;
      end
      return p + QUEUE_PTR_W'(1);
   endfunction

   assign pop = (count_ff != '0) && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         count_ff <= count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* sv/nms_keep_mask_gather.sv */
// Top level of the NMS keep-mask gather block: register port, walker, bitmap RMW, result queue.
//
//   channel  direction  handshake                   payload
//   req      in         req_valid / req_stall       req_mask_word
//   rsp      out        rsp_valid / rsp_stall       is_kept, kept_index, finished, kept_total
//   csr      in         csr_psel/penable/pwrite     box_count at byte address 0
//
// One mask word per cycle while req_stall is low; results pass the s1 registers and the queue.
// The bitmap RAM is read as the word is taken and written in the next cycle, with forwarding
// of the previous write so back-to-back words of the same entry see up-to-date bits.
// Reset (and any box_count write) clears counters and the per-word valid bits at once.
// req_stall rises when the result queue plus the word in flight could fill three entries.
module nms_keep_mask_gather #(
   parameter int MAX_BOXES = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [nmskg_pkg::MASK_W-1:0]         req_mask_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_kept,
   output logic [nmskg_pkg::INDEX_W-1:0]        rsp_kept_index,
   output logic                                 rsp_finished,
   output logic [nmskg_pkg::TOTAL_W-1:0]        rsp_kept_total,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [nmskg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nmskg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nmskg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import nmskg_pkg::*;

   localparam int DEPTH  = (MAX_BOXES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int N_W    = $clog2(MAX_BOXES + 1);

   logic [BOX_COUNT_W-1:0] box_count_ff;
   logic [N_W-1:0]         box_num;
   logic                   cfg_write;
   logic                   accept;

   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [WORD_BITS-1:0]   rd_data;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [WORD_BITS-1:0]   wr_data;

   logic                   s1_valid;
   logic [WORD_BITS-1:0]   s1_word;
   logic [ADDR_W-1:0]      s1_addr;
   logic [BIT_W-1:0]       s1_bit;
   logic [INDEX_W-1:0]     s1_row;
   walk_ctl_type           s1_ctl;

   logic                   push;
   rsp_type                push_data;
   rsp_type                rsp_data;
   logic [QUEUE_CNT_W-1:0] q_count;

   assign cfg_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[2] == REG_BOX_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         box_count_ff <= BOX_COUNT_RESET;
      end else if (cfg_write) begin
         box_count_ff <= csr_pwdata[BOX_COUNT_W-1:0];
      end
   end

   always_comb begin
      if (box_count_ff == '0) begin
         box_num = N_W'(1);
      end else if (32'(box_count_ff) > MAX_BOXES) begin
         box_num = N_W'(MAX_BOXES);
      end else begin
         box_num = N_W'(box_count_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BOX_COUNT) ? CSR_DATA_W'(box_count_ff) : '0;

   assign req_stall = (({1'b0, q_count} + (QUEUE_CNT_W + 1)'(s1_valid))
                       >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   nmskg_walk #(
      .MAX_BOXES (MAX_BOXES),
      .WORD_BITS (WORD_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .clear     (cfg_write),
      .accept    (accept),
      .box_num   (box_num),
      .mask_word (req_mask_word),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .s1_addr   (s1_addr),
      .s1_bit    (s1_bit),
      .s1_row    (s1_row),
      .s1_ctl    (s1_ctl)
   );

   nmskg_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_removed (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nmskg_rmw #(
      .MAX_BOXES (MAX_BOXES),
      .WORD_BITS (WORD_BITS)
   ) u_rmw (
      .clock     (clock),
      .reset     (reset),
      .clear     (cfg_write),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .s1_addr   (s1_addr),
      .s1_bit    (s1_bit),
      .s1_row    (s1_row),
      .s1_ctl    (s1_ctl),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .push      (push),
      .push_data (push_data)
   );

   nmskg_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .count     (q_count)
   );

   assign rsp_is_kept    = rsp_data.is_kept;
   assign rsp_kept_index = rsp_data.kept_index;
   assign rsp_finished   = rsp_data.finished;
   assign rsp_kept_total = rsp_data.kept_total;

endmodule

/* dv/nms_keep_mask_gather_tb.sv */
// Self-checking testbench for nms_keep_mask_gather: directed and random mask sets, predicted results.
`timescale 1ns / 1ps

module nms_keep_mask_gather_tb;
   import nmskg_pkg::*;

   localparam int MAX_BOXES      = 4096;
   localparam int WORD_BITS      = 32;
   localparam int STORE_WORDS    = MAX_BOXES / WORD_BITS;
   localparam int ITEM_TARGET    = 900;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] BOX_COUNT_ADDR = {REG_BOX_COUNT, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [MASK_W-1:0]     req_mask_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_is_kept;
   logic [INDEX_W-1:0]    rsp_kept_index;
   logic                  rsp_finished;
   logic [TOTAL_W-1:0]    rsp_kept_total;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [MASK_W-1:0]      removed_map [0:STORE_WORDS-1];
   int unsigned            walk_row;
   int unsigned            walk_word;
   int unsigned            keep_count;
   bit                     row_keeps;
   logic [BOX_COUNT_W-1:0] box_count_reg;
   rsp_type                pending_results [$];

   bit          idle_on = 1'b1;
   bit          rsp_hold_req = 1'b0;
   int unsigned words_sent = 0;
   int unsigned results_checked = 0;
   int unsigned kept_seen = 0;
   int unsigned sets_seen = 0;
   int unsigned fail_count = 0;
   int unsigned stuck_cycles = 0;

   nms_keep_mask_gather #(
      .MAX_BOXES(MAX_BOXES),
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mask_word  (req_mask_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_kept    (rsp_is_kept),
      .rsp_kept_index (rsp_kept_index),
      .rsp_finished   (rsp_finished),
      .rsp_kept_total (rsp_kept_total),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int unsigned set_size(input logic [BOX_COUNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_BOXES) return MAX_BOXES;
      return 32'(count);
   endfunction

   function automatic void clear_set_state();
      foreach (removed_map[i]) removed_map[i] = '0;
      walk_row   = 0;
      walk_word  = 0;
      keep_count = 0;
      row_keeps  = 1'b0;
   endfunction

   // one accepted mask word through the walk; queues a result when a box is kept or the set ends
   function automatic void track_mask_word(input logic [MASK_W-1:0] word);
      int unsigned boxes;
      int unsigned blocks;
      int unsigned row;
      int unsigned own;
      bit          kept_now;
      bit          set_done;
      rsp_type     res;
      boxes    = set_size(box_count_reg);
      blocks   = (boxes + WORD_BITS - 1) / WORD_BITS;
      row      = walk_row;
      own      = row / WORD_BITS;
      kept_now = 1'b0;
      set_done = 1'b0;
      if (walk_word == own) begin
         if (!removed_map[own][row % WORD_BITS]) begin
            kept_now  = 1'b1;
            row_keeps = 1'b1;
            keep_count++;
         end
         if (row_keeps) removed_map[own] |= word;
      end else if (walk_word > own && row_keeps) begin
         removed_map[walk_word] |= word;
      end
      walk_word++;
      if (walk_word >= blocks) begin
         walk_word = 0;
         row_keeps = 1'b0;
         walk_row++;
         if (walk_row >= boxes) begin
            walk_row = 0;
            set_done = 1'b1;
         end
      end
      if (kept_now || set_done) begin
         res.is_kept    = kept_now;
         res.kept_index = INDEX_W'(row);
         res.finished   = set_done;
         res.kept_total = TOTAL_W'(keep_count);
         pending_results.push_back(res);
         if (set_done) clear_set_state();
      end
   endfunction

   task automatic send_word(input logic [MASK_W-1:0] word);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mask_word <= word;
      do @(posedge clock); while (req_stall !== 1'b0);
      track_mask_word(word);
      words_sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= BOX_COUNT_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_box_count_reg();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(box_count_reg))
         note_failure($sformatf("box_count read: expected %0d, got %0d", box_count_reg, rd));
   endtask

   task automatic set_box_count(input int unsigned value);
      logic [CSR_DATA_W-1:0] ignored_rd;
      wait_results_drained();
      csr_access(1'b1, CSR_DATA_W'(value), ignored_rd);
      box_count_reg = BOX_COUNT_W'(value);
      clear_set_state();
      check_box_count_reg();
   endtask

   // random words; tidy sets keep only bits of later boxes in the row's own word
   task automatic send_box_set(input int unsigned boxes, input bit tidy, input int unsigned limit);
      int unsigned blocks;
      int unsigned sent;
      logic [MASK_W-1:0] w;
      blocks = (boxes + WORD_BITS - 1) / WORD_BITS;
      sent   = 0;
      for (int unsigned r = 0; r < boxes && sent < limit; r++) begin
         for (int unsigned c = 0; c < blocks && sent < limit; c++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: w = '0;
               4, 5, 6: begin
                  w = '0;
                  repeat ($urandom_range(1, 3)) w[$urandom_range(0, WORD_BITS - 1)] = 1'b1;
               end
               7, 8: w = $urandom;
               default: w = '1;
            endcase
            if (tidy && c == r / WORD_BITS) w &= 32'hFFFF_FFFE << (r % WORD_BITS);
            send_word(w);
            sent++;
         end
      end
   endtask

   task automatic test_reset_defaults();
      check_box_count_reg();
      send_word('0);
      send_word('1);
      send_word(32'h8000_0001);
   endtask

   task automatic test_zero_count();
      set_box_count(0);
      send_word('1);
      send_word('0);
   endtask

   task automatic test_small_sets();
      set_box_count(3);
      send_word(32'h0000_0002);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      // second box suppressed, so the end of set comes without a keep
      set_box_count(2);
      send_word(32'hFFFF_FFFF);
      send_word(32'h1234_5678);
   endtask

   task automatic test_abandoned_set();
      set_box_count(40);
      send_word(32'h0000_0004);
      send_word(32'h5555_5555);
      send_word('0);
      send_word(32'hAAAA_AAAA);
      send_word('0);
      send_word('1);
      send_word(32'h0000_0010);
      set_box_count(5);
      repeat (5) send_word('0);
   endtask

   task automatic test_saturated_count();
      set_box_count((1 << BOX_COUNT_W) - 1);
      send_box_set(MAX_BOXES, 1'b1, 130);
      set_box_count(MAX_BOXES);
      send_box_set(MAX_BOXES, 1'b1, 130);
   endtask

   task automatic test_backpressure();
      set_box_count(24);
      idle_on      = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (48) send_word('0);
      wait_results_drained();
      idle_on = 1'b1;
   endtask

   task automatic test_random_sets();
      int unsigned corner_counts [6] = '{0, 1, 31, 32, 33, 64};
      int unsigned value;
      int unsigned boxes;
      int unsigned words;
      int unsigned limit;
      int unsigned pick;
      bit          abandoned;
      abandoned = 1'b0;
      while (words_sent < ITEM_TARGET) begin
         if (abandoned || $urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) value = $urandom_range(1, 32);
            else if (pick < 17) value = $urandom_range(33, 48);
            else if (pick < 19) value = $urandom_range(49, 70);
            else value = corner_counts[$urandom_range(0, 5)];
            set_box_count(value);
         end
         boxes     = set_size(box_count_reg);
         words     = boxes * ((boxes + WORD_BITS - 1) / WORD_BITS);
         limit     = words;
         abandoned = 1'b0;
         if (words > 1 && $urandom_range(0, 7) == 0) begin
            limit     = $urandom_range(1, words - 1);
            abandoned = 1'b1;
         end
         idle_on = $urandom_range(0, 4) != 0;
         send_box_set(boxes, $urandom_range(0, 3) != 0, limit);
      end
      idle_on = 1'b1;
   endtask

   initial begin : rsp_side
      int unsigned n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            n = pick_gap();
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.is_kept    = rsp_is_kept;
         got.kept_index = rsp_kept_index;
         got.finished   = rsp_finished;
         got.kept_total = rsp_kept_total;
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected transaction: kept=%0b index=%0d finished=%0b total=%0d",
                                   got.is_kept, got.kept_index, got.finished, got.kept_total));
         end else begin
            want = pending_results.pop_front();
            if (got.is_kept !== want.is_kept || got.kept_index !== want.kept_index ||
                got.finished !== want.finished || got.kept_total !== want.kept_total)
               note_failure($sformatf({"transaction %0d: expected kept=%0b index=%0d finished=%0b",
                                       " total=%0d, got kept=%0b index=%0d finished=%0b total=%0d"},
                                      results_checked, want.is_kept, want.kept_index,
                                      want.finished, want.kept_total, got.is_kept,
                                      got.kept_index, got.finished, got.kept_total));
            results_checked++;
            if (want.is_kept) kept_seen++;
            if (want.finished) sets_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0)
          || csr_psel === 1'b1)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                  stuck_cycles, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mask_word = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      box_count_reg = BOX_COUNT_RESET;
      clear_set_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_count();
      test_small_sets();
      test_abandoned_set();
      test_saturated_count();
      test_backpressure();
      test_random_sets();
      wait_results_drained();

      $display("Sent %0d mask words; checked %0d results, %0d kept boxes, %0d completed sets.",
               words_sent, results_checked, kept_seen, sets_seen);
      $display("Box counts from zero to saturation, abandoned sets, long result hold-off, gaps.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d failures", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
